// ===== hw/rtl/psf_pkg.sv =====
// Shared types and constants of the planar span fill engine.
// Used by psf_cfg_regs and planar_span_fill; depends on nothing else.
package psf_pkg;

    // Configuration port geometry.
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    // Stream widths: fields packed from bit 0 up, tdata filled to whole bytes.
    localparam int S_TDATA_W = 56;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 64;
    localparam int M_TUSER_W = 3;

    // Register indexes, in address order (byte address is 4 * index).
    typedef enum logic [2:0] {
        REG_CLIP_LEFT       = 3'd0,
        REG_CLIP_TOP        = 3'd1,
        REG_CLIP_WIDTH      = 3'd2,
        REG_CLIP_HEIGHT     = 3'd3,
        REG_ROW_STRIDE      = 3'd4,
        REG_MASK_ROW_STRIDE = 3'd5,
        REG_MASK_ENABLE     = 3'd6
    } reg_idx_t;

    // Values after reset.
    localparam logic [9:0] RST_CLIP_LEFT       = 10'd0;
    localparam logic [8:0] RST_CLIP_TOP        = 9'd0;
    localparam logic [9:0] RST_CLIP_WIDTH      = 10'd320;
    localparam logic [8:0] RST_CLIP_HEIGHT     = 9'd200;
    localparam logic [9:0] RST_ROW_STRIDE      = 10'd160;
    localparam logic [7:0] RST_MASK_ROW_STRIDE = 8'd40;
    localparam logic       RST_MASK_ENABLE     = 1'b0;

    // Action on the mask plane.
    localparam logic [1:0] ACT_NONE  = 2'd0;
    localparam logic [1:0] ACT_CLEAR = 2'd1;
    localparam logic [1:0] ACT_SET   = 2'd2;

    // Configuration as seen by the span engine.
    typedef struct packed {
        logic [9:0] clip_left;
        logic [8:0] clip_top;
        logic [9:0] clip_width;
        logic [8:0] clip_height;
        logic [9:0] row_stride;
        logic [7:0] mask_row_stride;
        logic       mask_enable;
    } cfg_t;

endpackage

// ===== hw/rtl/planar_span_fill.sv =====
// Top level of the planar span fill engine: span sequencer and output beat register.
// Depends on psf_pkg and instantiates psf_cfg_regs.
//
// One span command enters per input beat and leaves as one output beat per
// 16-pixel group, left to right, with tlast on the final group. A span that
// is drawn is accepted, then set up (clip, two passes through the shared
// multiplier for the pixel and mask row offsets, one offset add) and then
// emits its groups, at most MAX_GROUPS of them. A span that is off the clip
// rectangle or an xor with colour 0 gives no beat and goes back to idle
// from the clip step. The input is not ready while a span is in work; it is
// ready again as soon as the last group sits in the output register, and a
// stalled output holds the engine.
module planar_span_fill #(
    parameter int MAX_GROUPS = 40
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // APB configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [psf_pkg::PADDR_W-1:0]    paddr,
    input  logic [psf_pkg::PDATA_W-1:0]    pwdata,
    output logic [psf_pkg::PDATA_W-1:0]    prdata,
    output logic                           pready,
    // Span commands
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // x_start[15:0], x_end[31:16], row[47:32], color[51:48], zero fill
    input  logic [psf_pkg::S_TDATA_W-1:0]  s_tdata,
    // op[0], transparent[1]
    input  logic [psf_pkg::S_TUSER_W-1:0]  s_tuser,
    // Group writes
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // pixel_offset[19:0], bit_mask[35:20], plane_bits[39:36],
    // mask_offset[59:40], zero fill
    output logic [psf_pkg::M_TDATA_W-1:0]  m_tdata,
    // write_kind[0], mask_action[2:1]
    output logic [psf_pkg::M_TUSER_W-1:0]  m_tuser,
    output logic                           m_tlast
);
    import psf_pkg::*;

    localparam logic [7:0] MaxM1 = 8'(MAX_GROUPS - 1);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_CLIP = 6'b000010,
        S_MULP = 6'b000100,
        S_MULM = 6'b001000,
        S_ADD  = 6'b010000,
        S_EMIT = 6'b100000
    } state_t;

    cfg_t cfg;

    state_t state_reg, state_next;

    // Captured command
    logic               op_reg;
    logic               transp_reg;
    logic [3:0]         color_reg;
    logic signed [15:0] xlo_reg, xhi_reg, y_reg;

    // Span setup
    logic [9:0]  yr_reg;
    logic [6:0]  g0_reg, gend_reg, g1_reg, g_reg;
    logic [15:0] lm_reg, rm_reg;
    logic [3:0]  planes_reg;
    logic [1:0]  action_reg;
    logic [19:0] pix_reg, msk_reg;

    // Output beat
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [M_TUSER_W-1:0] m_tuser_reg;
    logic                 m_tlast_reg;

    psf_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    logic s_fire, out_free;
    assign s_tready = (state_reg == S_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    // Clip against the rectangle in 18-bit signed arithmetic.
    logic signed [17:0] cl_s, cw_s, cr_s, ct_s, ch_s, cb_s;
    logic signed [17:0] y_s, xl_s, xh_s, x1c, x2c;
    logic               drop;
    assign cl_s = {8'd0, cfg.clip_left};
    assign cw_s = {8'd0, cfg.clip_width};
    assign cr_s = cl_s + cw_s - 18'sd1;
    assign ct_s = {9'd0, cfg.clip_top};
    assign ch_s = {9'd0, cfg.clip_height};
    assign cb_s = ct_s + ch_s;
    assign y_s  = {{2{y_reg[15]}}, y_reg};
    assign xl_s = {{2{xlo_reg[15]}}, xlo_reg};
    assign xh_s = {{2{xhi_reg[15]}}, xhi_reg};
    assign x1c  = (xl_s < cl_s) ? cl_s : xl_s;
    assign x2c  = (xh_s > cr_s) ? cr_s : xh_s;
    assign drop = (y_s < ct_s) || (y_s >= cb_s) || (x1c > x2c)
               || (op_reg && (color_reg == 4'd0));

    // Plane bits and mask action for the span.
    logic [3:0] planes_c;
    logic [1:0] action_c;
    always_comb begin
        planes_c = color_reg;
        action_c = cfg.mask_enable ? ACT_CLEAR : ACT_NONE;
        if (!op_reg && cfg.mask_enable && transp_reg) begin
            planes_c = 4'd0;
            action_c = ACT_SET;
        end
    end

    // Shared multiplier: row times pixel stride, then row times mask stride.
    logic [9:0]  mul_b;
    logic [19:0] prod;
    assign mul_b = (state_reg == S_MULP) ? cfg.row_stride : {2'd0, cfg.mask_row_stride};
    assign prod  = {10'd0, yr_reg} * {10'd0, mul_b};

    // Last group, limited to MAX_GROUPS groups.
    logic [7:0] span_c, g1_lim;
    assign span_c = {1'b0, gend_reg} - {1'b0, g0_reg};
    assign g1_lim = {1'b0, g0_reg} + MaxM1;

    // Edge mask of the current group.
    logic [15:0] bmask_c;
    always_comb begin
        bmask_c = 16'hFFFF;
        if (g_reg == g0_reg) begin
            bmask_c = bmask_c & lm_reg;
        end
        if (g_reg == gend_reg) begin
            bmask_c = bmask_c & rm_reg;
        end
    end

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (s_fire) state_next = S_CLIP;
            S_CLIP: state_next = drop ? S_IDLE : S_MULP;
            S_MULP: state_next = S_MULM;
            S_MULM: state_next = S_ADD;
            S_ADD:  state_next = S_EMIT;
            S_EMIT: if (out_free && (g_reg == g1_reg)) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_EMIT && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    op_reg     <= s_tuser[0];
                    transp_reg <= s_tuser[1];
                    color_reg  <= s_tdata[51:48];
                    y_reg      <= s_tdata[47:32];
                    // Order the two ends.
                    if ($signed(s_tdata[15:0]) > $signed(s_tdata[31:16])) begin
                        xlo_reg <= s_tdata[31:16];
                        xhi_reg <= s_tdata[15:0];
                    end else begin
                        xlo_reg <= s_tdata[15:0];
                        xhi_reg <= s_tdata[31:16];
                    end
                end
            end
            S_CLIP: begin
                yr_reg     <= y_s[9:0];
                g0_reg     <= x1c[10:4];
                gend_reg   <= x2c[10:4];
                lm_reg     <= 16'hFFFF >> x1c[3:0];
                rm_reg     <= 16'hFFFF << (4'd15 - x2c[3:0]);
                planes_reg <= planes_c;
                action_reg <= action_c;
            end
            S_MULP: begin
                pix_reg <= prod;
                g_reg   <= g0_reg;
                g1_reg  <= (span_c > MaxM1) ? g1_lim[6:0] : gend_reg;
            end
            S_MULM: begin
                msk_reg <= prod;
                pix_reg <= pix_reg + {10'd0, g0_reg, 3'd0};
            end
            S_ADD: begin
                msk_reg <= msk_reg + {12'd0, g0_reg, 1'b0};
            end
            S_EMIT: begin
                if (out_free) begin
                    m_tdata_reg <= {4'd0,
                                    cfg.mask_enable ? msk_reg : 20'd0,
                                    planes_reg, bmask_c, pix_reg};
                    m_tuser_reg <= {action_reg, op_reg};
                    m_tlast_reg <= (g_reg == g1_reg);
                    pix_reg     <= pix_reg + 20'd8;
                    msk_reg     <= msk_reg + 20'd2;
                    g_reg       <= g_reg + 7'd1;
                end
            end
            default: ;
        endcase
    end

    // Without a mask plane a beat carries no mask offset and no action.
    a_no_mask_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !cfg.mask_enable) |-> (m_tdata[59:40] == 20'd0
                                            && m_tuser[2:1] == ACT_NONE))
        else $error("mask fields set while mask plane is disabled");

    // A toggle write never sets mask bits.
    a_xor_no_set: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tuser[2:1] != ACT_SET))
        else $error("xor beat carries a mask set action");

    // Every emitted group touches at least one pixel.
    a_mask_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[35:20] != 16'd0))
        else $error("group beat with empty bit mask");

    // The group counter never runs past the last group.
    a_group_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EMIT) |-> (g_reg <= g1_reg))
        else $error("group counter past last group");

    // A new beat appears only out of the emit state.
    a_beat_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == S_EMIT))
        else $error("output beat loaded outside emit");

endmodule

// ===== hw/rtl/psf_cfg_regs.sv =====
// APB-style register file holding the clip rectangle, strides and mask enable.
// Depends on psf_pkg for the register indexes, reset values and cfg_t.
module psf_cfg_regs (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [psf_pkg::PADDR_W-1:0]  paddr,
    input  logic [psf_pkg::PDATA_W-1:0]  pwdata,
    output logic [psf_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    output psf_pkg::cfg_t                cfg
);
    import psf_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    // Register writes; an address past the last register is ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.clip_left       <= RST_CLIP_LEFT;
            cfg_reg.clip_top        <= RST_CLIP_TOP;
            cfg_reg.clip_width      <= RST_CLIP_WIDTH;
            cfg_reg.clip_height     <= RST_CLIP_HEIGHT;
            cfg_reg.row_stride      <= RST_ROW_STRIDE;
            cfg_reg.mask_row_stride <= RST_MASK_ROW_STRIDE;
            cfg_reg.mask_enable     <= RST_MASK_ENABLE;
        end else if (wr_en) begin
            case (idx)
                REG_CLIP_LEFT:       cfg_reg.clip_left       <= pwdata[9:0];
                REG_CLIP_TOP:        cfg_reg.clip_top        <= pwdata[8:0];
                REG_CLIP_WIDTH:      cfg_reg.clip_width      <= pwdata[9:0];
                REG_CLIP_HEIGHT:     cfg_reg.clip_height     <= pwdata[8:0];
                REG_ROW_STRIDE:      cfg_reg.row_stride      <= pwdata[9:0];
                REG_MASK_ROW_STRIDE: cfg_reg.mask_row_stride <= pwdata[7:0];
                REG_MASK_ENABLE:     cfg_reg.mask_enable     <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Read-back mux.
    always_comb begin
        prdata = '0;
        case (idx)
            REG_CLIP_LEFT:       prdata = {22'd0, cfg_reg.clip_left};
            REG_CLIP_TOP:        prdata = {23'd0, cfg_reg.clip_top};
            REG_CLIP_WIDTH:      prdata = {22'd0, cfg_reg.clip_width};
            REG_CLIP_HEIGHT:     prdata = {23'd0, cfg_reg.clip_height};
            REG_ROW_STRIDE:      prdata = {22'd0, cfg_reg.row_stride};
            REG_MASK_ROW_STRIDE: prdata = {24'd0, cfg_reg.mask_row_stride};
            REG_MASK_ENABLE:     prdata = {31'd0, cfg_reg.mask_enable};
            default:             prdata = '0;
        endcase
    end

endmodule
